[hw/rtl/line_follow_pd_drive_assert.svh]
`ifndef LINE_FOLLOW_PD_DRIVE_ASSERT_SVH
`define LINE_FOLLOW_PD_DRIVE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define LFPD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lfpd assertion failed");

// next-cycle implication, disabled in reset
`define LFPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lfpd assertion failed");

`endif

[hw/rtl/lfpd_pkg.sv]
package lfpd_pkg;

  localparam int ELAPSED_WIDTH = 24;

  // signed product widths of the numerator terms
  localparam int PA_W  = ELAPSED_WIDTH + 14;
  localparam int PB_W  = 34;
  localparam int NUM_W = ((PA_W > PB_W) ? PA_W : PB_W) + 1;
  localparam int CNT_W = $clog2(NUM_W);

  localparam logic signed [20:0] US_PER_SECOND = 21'sd1000000;

  typedef enum logic [2:0] {
    CFG_BASE_SPEED   = 3'd0,
    CFG_GAIN_P       = 3'd1,
    CFG_GAIN_D       = 3'd2,
    CFG_DRIVE_MIN    = 3'd3,
    CFG_DRIVE_MAX    = 3'd4,
    CFG_MOTOR_ENABLE = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [7:0]               sensor_bits;
    logic [ELAPSED_WIDTH-1:0] elapsed_us;
  } sense_t;

  typedef struct packed {
    logic [7:0]        left_fwd;
    logic [7:0]        left_bwd;
    logic [7:0]        right_fwd;
    logic [7:0]        right_bwd;
    logic signed [3:0] position_error;
  } cmd_t;

endpackage

[hw/rtl/line_follow_pd_drive.sv]
// PD line follower motor drive. Each sense transfer (sensor pattern plus elapsed
// microseconds) yields one cmd transfer carrying four PWM duties and the position
// error used. An item passes from acceptance through the MUL1, MUL2, SUM, DIV,
// CLAMP and OUT states to a loaded result; the DIV state is a restoring
// divider, which produces one quotient bit per cycle on a single shared
// compare/subtract unit. sense_stall is high while an item is in flight. The
// result sits in an output register, so the next item is taken while a result
// waits; a finished item waits in place only when that register is still full.
// Configuration writes are always ready and take effect immediately.
module line_follow_pd_drive (
  input  logic                clk,
  input  logic                rst,
  input  logic                sense_valid,
  output logic                sense_stall,
  input  lfpd_pkg::sense_t    sense,
  output logic                cmd_valid,
  input  logic                cmd_stall,
  output lfpd_pkg::cmd_t      cmd,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  lfpd_pkg::cfg_index_t cfg_index,
  input  logic [8:0]          cfg_data
);

  localparam int EW    = lfpd_pkg::ELAPSED_WIDTH;
  localparam int PA_W  = lfpd_pkg::PA_W;
  localparam int PB_W  = lfpd_pkg::PB_W;
  localparam int NUM_W = lfpd_pkg::NUM_W;
  localparam int CNT_W = lfpd_pkg::CNT_W;
  localparam int MV_W  = NUM_W + 2;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL1, S_MUL2, S_SUM, S_DIV, S_CLAMP, S_OUT
  } state_t;

  state_t state;

  logic [7:0]        base_speed, gain_p, gain_d, drive_max;
  logic signed [8:0] drive_min;
  logic              motor_enable;

  logic signed [3:0] prev_error, held_error, e_cur;
  logic signed [4:0] diff;
  logic [EW-1:0]     dt;
  logic signed [12:0] p_mul, q_mul;
  logic signed [PA_W-1:0] prod_a;
  logic signed [PB_W-1:0] prod_b;
  logic [NUM_W-1:0]  quo;
  logic              neg;
  logic [EW-1:0]     rem;
  logic [CNT_W-1:0]  cnt;
  logic signed [9:0] left_drv, right_drv;

  function automatic logic [4:0] table_lookup(input logic [7:0] s);
    logic [4:0] r;
    unique case (s)
      8'h18:   r = {1'b1, 4'sd0};
      8'h30:   r = {1'b1, 4'sd1};
      8'h20:   r = {1'b1, 4'sd2};
      8'h60:   r = {1'b1, 4'sd3};
      8'h40:   r = {1'b1, 4'sd4};
      8'hC0:   r = {1'b1, 4'sd5};
      8'h80:   r = {1'b1, 4'sd6};
      8'h0C:   r = {1'b1, -4'sd1};
      8'h04:   r = {1'b1, -4'sd2};
      8'h06:   r = {1'b1, -4'sd3};
      8'h02:   r = {1'b1, -4'sd4};
      8'h03:   r = {1'b1, -4'sd5};
      8'h01:   r = {1'b1, -4'sd6};
      default: r = 5'b0;
    endcase
    return r;
  endfunction

  function automatic logic signed [9:0] clamp_drive(input logic signed [MV_W-1:0] v,
                                                    input logic signed [8:0] lo,
                                                    input logic [7:0] hi);
    logic signed [MV_W-1:0] r, lo_x, hi_x;
    lo_x = MV_W'(lo);
    hi_x = $signed({{(MV_W-8){1'b0}}, hi});
    r = v;
    if (r < lo_x) r = lo_x;
    if (r > hi_x) r = hi_x;
    return r[9:0];
  endfunction

  function automatic logic [15:0] split_drive(input logic signed [9:0] v);
    logic signed [9:0] m;
    logic [15:0] r;
    m = -v;
    if (v > 10'sd0) r = {v[7:0], 8'd0};
    else if (m > 10'sd255) r = {8'd0, 8'hFF};
    else r = {8'd0, m[7:0]};
    return r;
  endfunction

  // error decode at acceptance
  logic [4:0]        lookup;
  logic signed [3:0] e_tab, e_sel, held_next;
  logic              sense_xfer;

  assign sense_xfer = sense_valid && !sense_stall;
  assign lookup     = table_lookup(sense.sensor_bits);
  assign e_tab      = lookup[4] ? $signed(lookup[3:0]) : prev_error;

  always_comb begin
    held_next = held_error;
    if (sense.sensor_bits[7] && (|sense.sensor_bits[4:0])) begin
      e_sel = held_error;
    end else if (sense.sensor_bits != 8'd0) begin
      e_sel     = e_tab;
      held_next = e_tab;
    end else begin
      e_sel = held_error;
    end
  end

  // numerator and divider step
  logic signed [NUM_W-1:0] num_sum;
  logic [EW:0]             rem_sh, rem_sub;
  logic                    ge;

  assign num_sum = NUM_W'(prod_a) + NUM_W'(prod_b);
  assign rem_sh  = {rem, quo[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, dt};
  assign rem_sub = rem_sh - {1'b0, dt};

  // move and side drives
  logic signed [MV_W-1:0] move, base_x, left_raw, right_raw;
  logic [15:0]            left_pwm, right_pwm;

  assign move      = neg ? -MV_W'($signed({1'b0, quo})) : MV_W'($signed({1'b0, quo}));
  assign base_x    = $signed({{(MV_W-8){1'b0}}, base_speed});
  assign left_raw  = base_x - move;
  assign right_raw = base_x + move;
  assign left_pwm  = split_drive(left_drv);
  assign right_pwm = split_drive(right_drv);

  assign sense_stall = (state != S_IDLE);
  assign cfg_ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cmd_valid    <= 1'b0;
      prev_error   <= 4'sd0;
      held_error   <= 4'sd0;
      base_speed   <= 8'd0;
      gain_p       <= 8'd0;
      gain_d       <= 8'd0;
      drive_min    <= -9'sd255;
      drive_max    <= 8'd255;
      motor_enable <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          lfpd_pkg::CFG_BASE_SPEED:   base_speed   <= cfg_data[7:0];
          lfpd_pkg::CFG_GAIN_P:       gain_p       <= cfg_data[7:0];
          lfpd_pkg::CFG_GAIN_D:       gain_d       <= cfg_data[7:0];
          lfpd_pkg::CFG_DRIVE_MIN:    drive_min    <= $signed(cfg_data);
          lfpd_pkg::CFG_DRIVE_MAX:    drive_max    <= cfg_data[7:0];
          lfpd_pkg::CFG_MOTOR_ENABLE: motor_enable <= cfg_data[0];
          default: ;
        endcase
      end

      if (cmd_valid && !cmd_stall && state != S_OUT) cmd_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (sense_xfer) begin
            e_cur      <= e_sel;
            diff       <= 5'(e_sel) - 5'(prev_error);
            prev_error <= e_sel;
            held_error <= held_next;
            dt         <= (sense.elapsed_us == '0) ? EW'(1) : sense.elapsed_us;
            state      <= S_MUL1;
          end
        end
        S_MUL1: begin
          p_mul <= 13'(e_cur) * $signed({5'b0, gain_p});
          q_mul <= 13'(diff) * $signed({5'b0, gain_d});
          state <= S_MUL2;
        end
        S_MUL2: begin
          prod_a <= PA_W'(p_mul) * $signed({{(PA_W-EW){1'b0}}, dt});
          prod_b <= PB_W'(q_mul) * PB_W'(lfpd_pkg::US_PER_SECOND);
          state  <= S_SUM;
        end
        S_SUM: begin
          neg   <= num_sum[NUM_W-1];
          quo   <= num_sum[NUM_W-1] ? NUM_W'(-num_sum) : NUM_W'(num_sum);
          rem   <= '0;
          cnt   <= CNT_W'(NUM_W - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= ge ? rem_sub[EW-1:0] : rem_sh[EW-1:0];
          quo <= {quo[NUM_W-2:0], ge};
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) state <= S_CLAMP;
        end
        S_CLAMP: begin
          left_drv  <= clamp_drive(left_raw, drive_min, drive_max);
          right_drv <= clamp_drive(right_raw, drive_min, drive_max);
          state     <= S_OUT;
        end
        S_OUT: begin
          if (!cmd_valid || !cmd_stall) begin
            cmd.left_fwd       <= motor_enable ? left_pwm[15:8] : 8'd0;
            cmd.left_bwd       <= motor_enable ? left_pwm[7:0] : 8'd0;
            cmd.right_fwd      <= motor_enable ? right_pwm[15:8] : 8'd0;
            cmd.right_bwd      <= motor_enable ? right_pwm[7:0] : 8'd0;
            cmd.position_error <= e_cur;
            cmd_valid          <= 1'b1;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/lfpd_checker.sv]
`include "line_follow_pd_drive_assert.svh"

module lfpd_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 sense_valid,
  input logic                 sense_stall,
  input logic                 cmd_valid,
  input logic                 cmd_stall,
  input lfpd_pkg::cmd_t       cmd
);

  logic err_in_range;
  logic one_direction;

  assign err_in_range  = ($signed(cmd.position_error) >= -4'sd6) &&
                         ($signed(cmd.position_error) <= 4'sd6);
  assign one_direction = (cmd.left_fwd == 8'd0 || cmd.left_bwd == 8'd0) &&
                         (cmd.right_fwd == 8'd0 || cmd.right_bwd == 8'd0);

  `LFPD_ASSERT_NEXT(a_cmd_hold, clk, rst, cmd_valid && cmd_stall, cmd_valid && $stable(cmd))

  `LFPD_ASSERT_NEXT(a_busy_after_xfer, clk, rst, sense_valid && !sense_stall, sense_stall)

  `LFPD_ASSERT_IMPLY(a_err_range, clk, rst, cmd_valid, err_in_range)

  `LFPD_ASSERT_IMPLY(a_one_direction, clk, rst, cmd_valid, one_direction)

endmodule

bind line_follow_pd_drive lfpd_checker u_lfpd_checker (
  .clk(clk), .rst(rst),
  .sense_valid(sense_valid), .sense_stall(sense_stall),
  .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd)
);
